// File: design/rfti_pkg.sv
package rfti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int W           = 32;
    localparam int LEN_W       = 11;
    localparam int TIDX_W      = 10;
    localparam int RAD_W       = 2 * W;
    localparam int IDX_W       = RAD_W - 2 * FRAC_BITS;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 64;

    localparam logic [W-1:0]     SPACING_RESET = 32'd65536;
    localparam logic [LEN_W-1:0] LEN_RESET     = 11'd1024;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SPACING = 1'b0;
    localparam t_cfg_idx CFG_LENGTH  = 1'b1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // sideband carried alongside the root extraction
    typedef struct packed {
        logic              valid;
        logic              func;
        logic              origin;
        logic              neg_x;
        logic              neg_y;
        logic [W-1:0]      ax;
        logic [W-1:0]      ay;
        logic [TIDX_W-1:0] tidx;
        logic [W-1:0]      tval;
    } t_sq_side;

    // sideband carried through the table read and interpolation
    typedef struct packed {
        logic         valid;
        logic         origin;
        logic         beyond;
        logic         neg_x;
        logic         neg_y;
        logic [W-1:0] ax;
        logic [W-1:0] ay;
        logic [W-1:0] r;
    } t_tb_side;

    // sideband carried through the dividers
    typedef struct packed {
        logic valid;
        logic origin;
        logic beyond;
        logic neg_x;
        logic neg_y;
    } t_dv_side;

endpackage

// File: design/rfti_sqrt.sv
module rfti_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rfti_pkg::RAD_W-1:0]    i_rad,
    input  rfti_pkg::t_sq_side            i_side,
    output logic [rfti_pkg::W-1:0]        o_root,
    output rfti_pkg::t_sq_side            o_side
);
    import rfti_pkg::*;

    // one root bit per stage
    logic [RAD_W-1:0] r_v    [0:W];
    logic [W+1:0]     r_rem  [0:W];
    logic [W-1:0]     r_root [0:W];
    t_sq_side         r_side [0:W];

    assign r_v[0]    = i_rad;
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_side[0] = i_side;

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [W+3:0] rem_t;
        logic [W+3:0] trial;
        logic         take;

        assign rem_t = {r_rem[g], r_v[g][RAD_W-1:RAD_W-2]};
        assign trial = {2'b00, r_root[g], 2'b01};
        assign take  = (rem_t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].valid <= 1'b0;
            end else if (i_en) begin
                r_side[g+1] <= r_side[g];
                r_v[g+1]    <= {r_v[g][RAD_W-3:0], 2'b00};
                r_rem[g+1]  <= take ? (W+2)'(rem_t - trial) : rem_t[W+1:0];
                r_root[g+1] <= {r_root[g][W-2:0], take};
            end
        end
    end

    assign o_root = r_root[W];
    assign o_side = r_side[W];

endmodule

// File: design/rfti_table.sv
module rfti_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_we,
    input  logic [rfti_pkg::AW-1:0]       i_waddr,
    input  logic [rfti_pkg::W-1:0]        i_wdata,
    input  logic [rfti_pkg::AW-1:0]       i_ra,
    input  logic [rfti_pkg::AW-1:0]       i_rb,
    input  logic [rfti_pkg::FRAC_BITS-1:0] i_frac,
    input  rfti_pkg::t_tb_side            i_side,
    output logic signed [rfti_pkg::W-1:0] o_mag,
    output rfti_pkg::t_tb_side            o_side
);
    import rfti_pkg::*;

    logic [W-1:0] r_mem [TABLE_DEPTH];

    // read stage
    logic signed [W-1:0]   r_a;
    logic signed [W-1:0]   r_b;
    logic [FRAC_BITS-1:0]  r_frac;
    t_tb_side              r_side1;
    // product stage
    logic signed [W-1:0]          r_a2;
    logic signed [FRAC_BITS+W+1:0] r_prod;
    t_tb_side                     r_side2;
    // sum stage
    logic signed [W-1:0] r_mag;
    t_tb_side            r_side3;

    logic signed [W:0]             diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [FRAC_BITS+W+1:0] n_prod;
    logic signed [W:0]             n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
            r_a <= r_mem[i_ra];
            r_b <= r_mem[i_rb];
        end
    end

    assign diff   = {r_b[W-1], r_b} - {r_a[W-1], r_a};
    assign frac_s = {1'b0, r_frac};
    assign n_prod = frac_s * diff;
    // arithmetic shift floors toward minus infinity
    assign n_sum  = {r_a2[W-1], r_a2} + (W+1)'(r_prod >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.valid <= 1'b0;
            r_side2.valid <= 1'b0;
            r_side3.valid <= 1'b0;
        end else if (i_en) begin
            r_frac  <= i_frac;
            r_side1 <= i_side;
            r_a2    <= r_a;
            r_prod  <= n_prod;
            r_side2 <= r_side1;
            r_mag   <= n_sum[W-1:0];
            r_side3 <= r_side2;
        end
    end

    assign o_mag  = r_mag;
    assign o_side = r_side3;

endmodule

// File: design/rfti_div.sv
module rfti_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [rfti_pkg::W-1:0]        i_den,
    input  logic [rfti_pkg::RAD_W-1:0]    i_num_x,
    input  logic [rfti_pkg::RAD_W-1:0]    i_num_y,
    input  rfti_pkg::t_dv_side            i_side,
    output logic [rfti_pkg::W-1:0]        o_quo_x,
    output logic [rfti_pkg::W-1:0]        o_quo_y,
    output rfti_pkg::t_dv_side            o_side
);
    import rfti_pkg::*;

    // restoring division, one quotient bit per stage for both lanes;
    // the quotient shifts into the low word as the dividend bits leave it
    logic [W-1:0] r_den   [0:W];
    logic [W-1:0] r_rem_x [0:W];
    logic [W-1:0] r_lo_x  [0:W];
    logic [W-1:0] r_rem_y [0:W];
    logic [W-1:0] r_lo_y  [0:W];
    t_dv_side     r_side  [0:W];

    assign r_den[0]   = i_den;
    assign r_rem_x[0] = i_num_x[RAD_W-1:W];
    assign r_lo_x[0]  = i_num_x[W-1:0];
    assign r_rem_y[0] = i_num_y[RAD_W-1:W];
    assign r_lo_y[0]  = i_num_y[W-1:0];
    assign r_side[0]  = i_side;

    for (genvar g = 0; g < W; g++) begin : g_stage
        logic [W:0] tx;
        logic [W:0] ty;
        logic [W:0] dd;
        logic       gx;
        logic       gy;

        assign dd = {1'b0, r_den[g]};
        assign tx = {r_rem_x[g], r_lo_x[g][W-1]};
        assign ty = {r_rem_y[g], r_lo_y[g][W-1]};
        assign gx = (tx >= dd);
        assign gy = (ty >= dd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[g+1].valid <= 1'b0;
            end else if (i_en) begin
                r_side[g+1]  <= r_side[g];
                r_den[g+1]   <= r_den[g];
                r_rem_x[g+1] <= gx ? W'(tx - dd) : tx[W-1:0];
                r_rem_y[g+1] <= gy ? W'(ty - dd) : ty[W-1:0];
                r_lo_x[g+1]  <= {r_lo_x[g][W-2:0], gx};
                r_lo_y[g+1]  <= {r_lo_y[g][W-2:0], gy};
            end
        end
    end

    assign o_quo_x = r_lo_x[W];
    assign o_quo_y = r_lo_y[W];
    assign o_side  = r_side[W];

endmodule

// File: design/radial_force_table_interp.sv
// Channel   Dir  Beat contents (tdata / tuser)
// s_axis    in   tdata: pos_x, pos_y, table_index, table_value; tuser: func
// m_axis    out  tdata: force_x, force_y; tuser: beyond_table, at_origin
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// One beat per cycle unless the output stalls. Evaluate beats pass through the
// 32-stage root extraction and the 32-stage divider. Load beats write the
// table when they reach the read stage and give no output beat.
// Synchronous active-low reset clears the valid bits and the config registers.
// The whole pipeline holds while an output beat waits and m_axis_tready is low.
module radial_force_table_interp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [31:0] pos_x, [63:32] pos_y, [73:64] table_index, [105:74] table_value
    input  logic [rfti_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] func
    input  logic [0:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] force_x, [63:32] force_y
    output logic [rfti_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] beyond_table, [1] at_origin
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 i_cfg_we,
    input  rfti_pkg::t_cfg_idx                   i_cfg_idx,
    input  logic [rfti_pkg::W-1:0]               i_cfg_data
);
    import rfti_pkg::*;

    logic en;

    // configuration
    logic [W-1:0]     r_spacing;
    logic [LEN_W-1:0] r_len;
    logic [AW-1:0]    lenm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
            r_len     <= LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPACING: r_spacing <= i_cfg_data;
                CFG_LENGTH:  r_len     <= i_cfg_data[LEN_W-1:0];
                default:     r_spacing <= r_spacing;
            endcase
        end
    end

    always_comb begin
        priority if (r_len < LEN_W'(2)) begin
            lenm1 = AW'(1);
        end else if (32'(r_len) > TABLE_DEPTH) begin
            lenm1 = AW'(TABLE_DEPTH - 1);
        end else begin
            lenm1 = AW'(r_len - LEN_W'(1));
        end
    end

    // input fields
    logic signed [W-1:0] in_x;
    logic signed [W-1:0] in_y;
    t_sq_side            n_s1;

    assign in_x = s_axis_tdata[W-1:0];
    assign in_y = s_axis_tdata[2*W-1:W];

    always_comb begin
        n_s1.valid  = s_axis_tvalid;
        n_s1.func   = s_axis_tuser[0];
        n_s1.origin = (in_x == '0) && (in_y == '0);
        n_s1.neg_x  = in_x[W-1];
        n_s1.neg_y  = in_y[W-1];
        n_s1.ax     = in_x[W-1] ? W'(-in_x) : in_x;
        n_s1.ay     = in_y[W-1] ? W'(-in_y) : in_y;
        n_s1.tidx   = s_axis_tdata[2*W+TIDX_W-1:2*W];
        n_s1.tval   = s_axis_tdata[3*W+TIDX_W-1:2*W+TIDX_W];
    end

    // squares, then their sum
    t_sq_side         r_s1;
    t_sq_side         r_s2;
    t_sq_side         r_s3;
    logic [RAD_W-1:0] r_sqx;
    logic [RAD_W-1:0] r_sqy;
    logic [RAD_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (en) begin
            r_s1  <= n_s1;
            r_s2  <= r_s1;
            r_sqx <= r_s1.ax * r_s1.ax;
            r_sqy <= r_s1.ay * r_s1.ay;
            r_s3  <= r_s2;
            r_sum <= r_sqx + r_sqy;
        end
    end

    logic [W-1:0] sq_root;
    t_sq_side     sq_side;

    rfti_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (r_sum),
        .i_side  (r_s3),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // scale by spacing reciprocal, then split into index and fraction
    t_sq_side         r_s4;
    logic [W-1:0]     r_s4_r;
    logic [RAD_W-1:0] r_scaled;

    logic [IDX_W-1:0]     idx;
    logic [FRAC_BITS-1:0] frac;
    logic                 beyond;
    logic                 is_eval;

    assign idx     = r_scaled[RAD_W-1:2*FRAC_BITS];
    assign frac    = r_scaled[2*FRAC_BITS-1:FRAC_BITS];
    assign beyond  = (idx >= IDX_W'(lenm1));
    assign is_eval = (r_s4.func == FUNC_EVAL);

    logic                 r_s5_we;
    logic [AW-1:0]        r_s5_waddr;
    logic [W-1:0]         r_s5_wdata;
    logic [AW-1:0]        r_s5_ra;
    logic [AW-1:0]        r_s5_rb;
    logic [FRAC_BITS-1:0] r_s5_frac;
    t_tb_side             r_s5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.valid <= 1'b0;
            r_s5.valid <= 1'b0;
            r_s5_we    <= 1'b0;
        end else if (en) begin
            r_s4       <= sq_side;
            r_s4_r     <= sq_root;
            r_scaled   <= sq_root * r_spacing;

            r_s5_we    <= r_s4.valid && !is_eval && (32'(r_s4.tidx) < TABLE_DEPTH);
            r_s5_waddr <= AW'(r_s4.tidx);
            r_s5_wdata <= r_s4.tval;
            r_s5_ra    <= beyond ? lenm1 : idx[AW-1:0];
            r_s5_rb    <= beyond ? lenm1 : idx[AW-1:0] + AW'(1);
            // past the last sample the fraction is dropped: the word at ra is used
            r_s5_frac  <= beyond ? '0 : frac;

            r_s5.valid  <= r_s4.valid && is_eval;
            r_s5.origin <= r_s4.origin;
            r_s5.beyond <= beyond && !r_s4.origin;
            r_s5.neg_x  <= r_s4.neg_x;
            r_s5.neg_y  <= r_s4.neg_y;
            r_s5.ax     <= r_s4.ax;
            r_s5.ay     <= r_s4.ay;
            r_s5.r      <= r_s4_r;
        end
    end

    logic signed [W-1:0] mag;
    t_tb_side            tb_side;

    rfti_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_we    (r_s5_we),
        .i_waddr (r_s5_waddr),
        .i_wdata (r_s5_wdata),
        .i_ra    (r_s5_ra),
        .i_rb    (r_s5_rb),
        .i_frac  (r_s5_frac),
        .i_side  (r_s5),
        .o_mag   (mag),
        .o_side  (tb_side)
    );

    // component products |c| * |m|
    logic [W-1:0]     mag_abs;
    logic [RAD_W-1:0] r_px;
    logic [RAD_W-1:0] r_py;
    logic [W-1:0]     r_s6_r;
    t_dv_side         r_s6;

    assign mag_abs = mag[W-1] ? W'(-mag) : mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.valid <= 1'b0;
        end else if (en) begin
            r_px        <= tb_side.ax * mag_abs;
            r_py        <= tb_side.ay * mag_abs;
            r_s6_r      <= tb_side.r;
            r_s6.valid  <= tb_side.valid;
            r_s6.origin <= tb_side.origin;
            r_s6.beyond <= tb_side.beyond;
            r_s6.neg_x  <= tb_side.neg_x ^ mag[W-1];
            r_s6.neg_y  <= tb_side.neg_y ^ mag[W-1];
        end
    end

    logic [W-1:0] qx;
    logic [W-1:0] qy;
    t_dv_side     dv_side;

    rfti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_den   (r_s6_r),
        .i_num_x (r_px),
        .i_num_y (r_py),
        .i_side  (r_s6),
        .o_quo_x (qx),
        .o_quo_y (qy),
        .o_side  (dv_side)
    );

    // quotient never exceeds 2^31, so bit 31 alone decides saturation
    function automatic logic [W-1:0] apply_sign(input logic [W-1:0] q, input logic neg);
        logic [W-1:0] res;
        if (neg) begin
            res = q[W-1] ? {1'b1, {(W-1){1'b0}}} : W'(-q);
        end else begin
            res = q[W-1] ? {1'b0, {(W-1){1'b1}}} : q;
        end
        return res;
    endfunction

    logic         r_out_valid;
    logic [W-1:0] r_fx;
    logic [W-1:0] r_fy;
    logic         r_beyond;
    logic         r_origin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_side.valid;
            r_fx        <= dv_side.origin ? '0 : apply_sign(qx, dv_side.neg_x);
            r_fy        <= dv_side.origin ? '0 : apply_sign(qy, dv_side.neg_y);
            r_beyond    <= dv_side.beyond;
            r_origin    <= dv_side.origin;
        end
    end

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_fy, r_fx};
    assign m_axis_tuser  = {r_origin, r_beyond};

endmodule
